[src/mfvn_pkg.sv]
`timescale 1ns / 1ps

package mfvn_pkg;

  // mesh capacity
  localparam int MAX_VERTICES = 4096;
  localparam int MAX_FACES    = 4096;

  localparam int VIDX_W     = $clog2(MAX_VERTICES);
  localparam int FIDX_W     = $clog2(MAX_FACES);
  // a stored corner saturates at MAX_VERTICES so that out-of-range stays out of range
  localparam int CORNER_W   = $clog2(MAX_VERTICES + 1);
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 32;
  localparam int NRM_W      = 16;
  localparam int SUM_W      = 32;
  localparam int POS_WORD_W = 3 * POS_W;
  localparam int SUM_WORD_W = 3 * SUM_W;
  localparam int CRN_WORD_W = 3 * CORNER_W;
  localparam int FN_WORD_W  = 3 * NRM_W + 1;

  // function codes
  localparam logic [2:0] FUNC_LOAD_VERTEX = 3'd0;
  localparam logic [2:0] FUNC_LOAD_FACE   = 3'd1;
  localparam logic [2:0] FUNC_COMPUTE     = 3'd2;
  localparam logic [2:0] FUNC_READ_FACE   = 3'd3;
  localparam logic [2:0] FUNC_READ_VERTEX = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_DEGEN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_COUNT   = 4'd1;

  typedef struct packed {
    logic [2:0]         func;
    logic [11:0]        index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
  } req_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec64_t;

  typedef struct packed {
    logic               done;
    logic               degen;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } norm_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FREAD, ST_VREAD, ST_VNORM, ST_CLEAR, ST_FADDR, ST_FCHECK,
    ST_PA, ST_PB, ST_PC, ST_DSHIFT, ST_MUL, ST_FNORM, ST_SADDR, ST_SUPD, ST_CDONE
  } seq_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQUARE, N_ROOT, N_DINIT, N_DIV, N_DONE
  } norm_state_t;

endpackage

[src/mfvn_ram.sv]
`timescale 1ns / 1ps

module mfvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mfvn_norm.sv]
`timescale 1ns / 1ps

module mfvn_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mfvn_pkg::vec64_t    vec,
  output mfvn_pkg::norm_res_t res
);

  mfvn_pkg::norm_state_t state, state_next;

  logic [63:0]        m [3];
  logic               neg [3];
  logic [1:0]         cnt;
  logic [61:0]        sq;
  logic [63:0]        acc;
  logic [63:0]        root;
  logic [63:0]        rbit;
  logic [32:0]        rem;
  logic [14:0]        numlo;
  logic [14:0]        quo;
  logic [3:0]         dcnt;
  logic               degen;
  logic signed [15:0] outv [3];

  logic [30:0] sq_in;
  logic [30:0] div_in;
  logic        big;
  logic [63:0] rb_sum;
  logic        root_ge;
  logic [32:0] len;
  logic [46:0] num_c;
  logic [33:0] trial;
  logic        div_ge;
  logic [14:0] quo_next;

  // operand selection and step logic
  always_comb begin
    unique case (cnt)
      2'd0:    sq_in = m[0][30:0];
      2'd1:    sq_in = m[1][30:0];
      default: sq_in = m[2][30:0];
    endcase
    unique case (cnt)
      2'd0:    div_in = m[0][30:0];
      2'd1:    div_in = m[1][30:0];
      default: div_in = m[2][30:0];
    endcase
    big      = (|m[0][63:31]) | (|m[1][63:31]) | (|m[2][63:31]);
    rb_sum   = root + rbit;
    root_ge  = acc >= rb_sum;
    len      = root[32:0];
    num_c    = {2'b00, div_in, 14'b0} + 47'(len[32:1]);
    trial    = {rem, numlo[14]};
    div_ge   = trial >= {1'b0, len};
    quo_next = {quo[13:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfvn_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mfvn_pkg::N_IDLE:   if (start) state_next = mfvn_pkg::N_SHIFT;
      mfvn_pkg::N_SHIFT:  if (!big) state_next = mfvn_pkg::N_SQUARE;
      mfvn_pkg::N_SQUARE: if (cnt == 2'd3) state_next = mfvn_pkg::N_ROOT;
      mfvn_pkg::N_ROOT:   if (rbit == 64'd1) state_next = mfvn_pkg::N_DINIT;
      mfvn_pkg::N_DINIT: begin
        if (len == '0) state_next = mfvn_pkg::N_DONE;
        else state_next = mfvn_pkg::N_DIV;
      end
      mfvn_pkg::N_DIV: begin
        if (dcnt == 4'd0) begin
          if (cnt == 2'd2) state_next = mfvn_pkg::N_DONE;
          else state_next = mfvn_pkg::N_DINIT;
        end
      end
      mfvn_pkg::N_DONE:   state_next = mfvn_pkg::N_IDLE;
      default:            state_next = mfvn_pkg::N_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mfvn_pkg::N_IDLE: begin
        neg[0] <= vec.x < 0;
        neg[1] <= vec.y < 0;
        neg[2] <= vec.z < 0;
        m[0]   <= (vec.x < 0) ? 64'(-vec.x) : 64'(vec.x);
        m[1]   <= (vec.y < 0) ? 64'(-vec.y) : 64'(vec.y);
        m[2]   <= (vec.z < 0) ? 64'(-vec.z) : 64'(vec.z);
        cnt    <= 2'd0;
        acc    <= '0;
      end
      // common shift toward zero until the largest fits 31 bits
      mfvn_pkg::N_SHIFT: begin
        if (big) begin
          m[0] <= m[0] >> 1;
          m[1] <= m[1] >> 1;
          m[2] <= m[2] >> 1;
        end
      end
      // squares, one per cycle, each summed in the next cycle
      mfvn_pkg::N_SQUARE: begin
        if (cnt != 2'd3) sq <= sq_in * sq_in;
        if (cnt != 2'd0) acc <= acc + 64'(sq);
        cnt  <= cnt + 2'd1;
        root <= '0;
        rbit <= 64'd1 << 62;
      end
      // integer square root, two bits of radicand per cycle
      mfvn_pkg::N_ROOT: begin
        if (root_ge) begin
          acc  <= acc - rb_sum;
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
        cnt  <= 2'd0;
      end
      mfvn_pkg::N_DINIT: begin
        degen <= (len == '0);
        if (len == '0) begin
          outv[0] <= '0;
          outv[1] <= '0;
          outv[2] <= '0;
        end
        rem   <= 33'(num_c[46:15]);
        numlo <= num_c[14:0];
        quo   <= '0;
        dcnt  <= 4'd14;
      end
      // restoring divide, one quotient bit per cycle
      mfvn_pkg::N_DIV: begin
        rem   <= div_ge ? 33'(trial - {1'b0, len}) : trial[32:0];
        numlo <= {numlo[13:0], 1'b0};
        quo   <= quo_next;
        dcnt  <= dcnt - 4'd1;
        if (dcnt == 4'd0) begin
          unique case (cnt)
            2'd0:    outv[0] <= neg[0] ? -16'(quo_next) : 16'(quo_next);
            2'd1:    outv[1] <= neg[1] ? -16'(quo_next) : 16'(quo_next);
            default: outv[2] <= neg[2] ? -16'(quo_next) : 16'(quo_next);
          endcase
          cnt <= cnt + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.done  = (state == mfvn_pkg::N_DONE);
  assign res.degen = degen;
  assign res.x     = outv[0];
  assign res.y     = outv[1];
  assign res.z     = outv[2];

endmodule

[src/mesh_face_and_vertex_normals_unit.sv]
`timescale 1ns / 1ps

// channel   | signals                                   | handshake
// ----------+-------------------------------------------+---------------------------
// request   | start, busy, request (req_t)              | word taken at start & !busy
// result    | done, result (res_t)                      | one cycle per word, no stall
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// Loads and out-of-range requests: one per cycle, result the cycle after.
// Face read: one pass through the face-normal memory. Vertex read: runs the sequential
// square root (32 steps) and the divider (one quotient bit per step) in the normalizer.
// Compute: clears all MAX_VERTICES vertex sums, then runs the normalizer again for each face;
// a face with a bad corner skips the normalizer.
// rst is synchronous; it clears control state only. cfg_ready is always high.

module mesh_face_and_vertex_normals_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mfvn_pkg::req_t                      request,
  output logic                                done,
  output mfvn_pkg::res_t                      result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfvn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfvn_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VW = mfvn_pkg::VIDX_W;
  localparam int FW = mfvn_pkg::FIDX_W;
  localparam int CW = mfvn_pkg::CORNER_W;

  mfvn_pkg::seq_state_t state, state_next;

  logic [mfvn_pkg::CNT_W-1:0] vcount, fcount, nv, nf;
  logic                       sums_valid;
  logic                       bad_acc, degen_acc;
  logic [FW-1:0]              face;
  logic [VW-1:0]              clr_addr;
  logic [1:0]                 k;
  logic [2:0]                 mcnt;
  logic [CW-1:0]              corner [3];
  logic signed [31:0]         pa [3];
  logic signed [31:0]         pb [3];
  logic signed [32:0]         d33 [6];
  logic signed [30:0]         d [6];
  logic signed [61:0]         prod;
  logic signed [63:0]         cr [3];
  logic signed [15:0]         nrm [3];

  logic accept;
  logic vtx_ok, face_ok, load_bad;
  logic [CW-1:0] sat_a, sat_b, sat_c;
  logic [CW-1:0] rc [3];
  logic          rc_bad;
  logic          last_face;

  // memories
  logic                            pos_we;
  logic [VW-1:0]                   pos_raddr;
  logic [mfvn_pkg::POS_WORD_W-1:0] pos_rdata;
  logic                            crn_we;
  logic [mfvn_pkg::CRN_WORD_W-1:0] crn_rdata;
  logic                            fn_we;
  logic [mfvn_pkg::FN_WORD_W-1:0]  fn_wdata, fn_rdata;
  logic                            sum_we;
  logic [VW-1:0]                   sum_waddr, sum_raddr;
  logic [mfvn_pkg::SUM_WORD_W-1:0] sum_wdata, sum_rdata;
  logic signed [31:0]              sx, sy, sz;

  logic                start_norm;
  mfvn_pkg::vec64_t    norm_vec;
  mfvn_pkg::norm_res_t norm_res;

  logic [31:0] dmag [6];
  logic [31:0] dor;
  logic [1:0]  dsh;
  logic signed [30:0] opa, opb;

  assign accept    = start && !busy;
  assign busy      = (state != mfvn_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective counts
  assign nv = (32'(vcount) > mfvn_pkg::MAX_VERTICES) ?
              mfvn_pkg::CNT_W'(mfvn_pkg::MAX_VERTICES) : vcount;
  assign nf = (32'(fcount) > mfvn_pkg::MAX_FACES) ?
              mfvn_pkg::CNT_W'(mfvn_pkg::MAX_FACES) : fcount;

  // saturated corners for a face load
  always_comb begin
    sat_a = (32'(request.corner_a) >= mfvn_pkg::MAX_VERTICES) ?
            CW'(mfvn_pkg::MAX_VERTICES) : CW'(request.corner_a);
    sat_b = (32'(request.corner_b) >= mfvn_pkg::MAX_VERTICES) ?
            CW'(mfvn_pkg::MAX_VERTICES) : CW'(request.corner_b);
    sat_c = (32'(request.corner_c) >= mfvn_pkg::MAX_VERTICES) ?
            CW'(mfvn_pkg::MAX_VERTICES) : CW'(request.corner_c);
    load_bad = (32'(sat_a) >= 32'(nv)) || (32'(sat_b) >= 32'(nv)) ||
               (32'(sat_c) >= 32'(nv));
    vtx_ok  = 32'(request.index) < mfvn_pkg::MAX_VERTICES;
    face_ok = 32'(request.index) < mfvn_pkg::MAX_FACES;
  end

  // corners read back during compute
  always_comb begin
    rc[0]  = crn_rdata[3*CW-1:2*CW];
    rc[1]  = crn_rdata[2*CW-1:CW];
    rc[2]  = crn_rdata[CW-1:0];
    rc_bad = (32'(rc[0]) >= 32'(nv)) || (32'(rc[1]) >= 32'(nv)) ||
             (32'(rc[2]) >= 32'(nv));
    last_face = 32'(face) == (32'(nf) - 32'd1);
  end

  // edge differences brought below 2^30 by one common shift
  always_comb begin
    dor = '0;
    for (int i = 0; i < 6; i++) begin
      dmag[i] = (d33[i] < 0) ? 32'(-d33[i]) : 32'(d33[i]);
      dor     = dor | dmag[i];
    end
    dsh = dor[31] ? 2'd2 : (dor[30] ? 2'd1 : 2'd0);
  end

  // multiplier operands for the cross product
  always_comb begin
    unique case (mcnt)
      3'd0:    begin opa = d[1]; opb = d[5]; end
      3'd1:    begin opa = d[2]; opb = d[4]; end
      3'd2:    begin opa = d[2]; opb = d[3]; end
      3'd3:    begin opa = d[0]; opb = d[5]; end
      3'd4:    begin opa = d[0]; opb = d[4]; end
      default: begin opa = d[1]; opb = d[3]; end
    endcase
  end

  // memory address and write control
  assign sx = sum_rdata[95:64];
  assign sy = sum_rdata[63:32];
  assign sz = sum_rdata[31:0];

  always_comb begin
    pos_we = accept && (request.func == mfvn_pkg::FUNC_LOAD_VERTEX) && vtx_ok;
    crn_we = accept && (request.func == mfvn_pkg::FUNC_LOAD_FACE) && face_ok;
    unique case (state)
      mfvn_pkg::ST_PA: pos_raddr = VW'(corner[1]);
      mfvn_pkg::ST_PB: pos_raddr = VW'(corner[2]);
      default:         pos_raddr = VW'(rc[0]);
    endcase
    fn_we    = ((state == mfvn_pkg::ST_FCHECK) && rc_bad) ||
               ((state == mfvn_pkg::ST_FNORM) && norm_res.done);
    fn_wdata = (state == mfvn_pkg::ST_FCHECK) ? {1'b1, 48'b0} :
               {1'b0, norm_res.x, norm_res.y, norm_res.z};
    sum_we    = (state == mfvn_pkg::ST_CLEAR) || (state == mfvn_pkg::ST_SUPD);
    sum_waddr = (state == mfvn_pkg::ST_CLEAR) ? clr_addr : VW'(corner[k]);
    sum_wdata = (state == mfvn_pkg::ST_CLEAR) ? '0 :
                {sx + 32'(nrm[0]), sy + 32'(nrm[1]), sz + 32'(nrm[2])};
    sum_raddr = (state == mfvn_pkg::ST_SADDR) ? VW'(corner[k]) : VW'(request.index);
  end

  mfvn_ram #(.WIDTH(mfvn_pkg::POS_WORD_W), .DEPTH(mfvn_pkg::MAX_VERTICES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(VW'(request.index)),
    .wdata({request.pos_x, request.pos_y, request.pos_z}),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  mfvn_ram #(.WIDTH(mfvn_pkg::CRN_WORD_W), .DEPTH(mfvn_pkg::MAX_FACES)) u_crn (
    .clk(clk), .we(crn_we), .waddr(FW'(request.index)),
    .wdata({sat_a, sat_b, sat_c}),
    .raddr(face), .rdata(crn_rdata)
  );

  mfvn_ram #(.WIDTH(mfvn_pkg::FN_WORD_W), .DEPTH(mfvn_pkg::MAX_FACES)) u_fn (
    .clk(clk), .we(fn_we), .waddr(face), .wdata(fn_wdata),
    .raddr(FW'(request.index)), .rdata(fn_rdata)
  );

  mfvn_ram #(.WIDTH(mfvn_pkg::SUM_WORD_W), .DEPTH(mfvn_pkg::MAX_VERTICES)) u_sum (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  // normalizer shared by face and vertex normals
  always_comb begin
    start_norm = (state == mfvn_pkg::ST_VREAD) ||
                 ((state == mfvn_pkg::ST_MUL) && (mcnt == 3'd7));
    if (state == mfvn_pkg::ST_VREAD) begin
      norm_vec.x = sums_valid ? 64'(sx) : '0;
      norm_vec.y = sums_valid ? 64'(sy) : '0;
      norm_vec.z = sums_valid ? 64'(sz) : '0;
    end else begin
      norm_vec.x = cr[0];
      norm_vec.y = cr[1];
      norm_vec.z = cr[2];
    end
  end

  mfvn_norm u_norm (
    .clk(clk), .rst(rst), .start(start_norm), .vec(norm_vec), .res(norm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfvn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      mfvn_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (request.func == mfvn_pkg::FUNC_COMPUTE) begin
            if (nv != '0 && nf != '0) state_next = mfvn_pkg::ST_CLEAR;
          end else if (request.func == mfvn_pkg::FUNC_READ_FACE) begin
            if (32'(request.index) < 32'(nf)) state_next = mfvn_pkg::ST_FREAD;
          end else if (request.func == mfvn_pkg::FUNC_READ_VERTEX) begin
            if (32'(request.index) < 32'(nv)) state_next = mfvn_pkg::ST_VREAD;
          end else begin
            state_next = mfvn_pkg::ST_IDLE;
          end
        end
      end
      mfvn_pkg::ST_FREAD:  state_next = mfvn_pkg::ST_IDLE;
      mfvn_pkg::ST_VREAD:  state_next = mfvn_pkg::ST_VNORM;
      mfvn_pkg::ST_VNORM:  if (norm_res.done) state_next = mfvn_pkg::ST_IDLE;
      mfvn_pkg::ST_CLEAR: begin
        if (clr_addr == VW'(mfvn_pkg::MAX_VERTICES - 1)) state_next = mfvn_pkg::ST_FADDR;
      end
      mfvn_pkg::ST_FADDR:  state_next = mfvn_pkg::ST_FCHECK;
      mfvn_pkg::ST_FCHECK: begin
        if (!rc_bad) state_next = mfvn_pkg::ST_PA;
        else if (last_face) state_next = mfvn_pkg::ST_CDONE;
        else state_next = mfvn_pkg::ST_FADDR;
      end
      mfvn_pkg::ST_PA:     state_next = mfvn_pkg::ST_PB;
      mfvn_pkg::ST_PB:     state_next = mfvn_pkg::ST_PC;
      mfvn_pkg::ST_PC:     state_next = mfvn_pkg::ST_DSHIFT;
      mfvn_pkg::ST_DSHIFT: state_next = mfvn_pkg::ST_MUL;
      mfvn_pkg::ST_MUL:    if (mcnt == 3'd7) state_next = mfvn_pkg::ST_FNORM;
      mfvn_pkg::ST_FNORM:  if (norm_res.done) state_next = mfvn_pkg::ST_SADDR;
      mfvn_pkg::ST_SADDR:  state_next = mfvn_pkg::ST_SUPD;
      mfvn_pkg::ST_SUPD: begin
        if (k != 2'd2) state_next = mfvn_pkg::ST_SADDR;
        else if (last_face) state_next = mfvn_pkg::ST_CDONE;
        else state_next = mfvn_pkg::ST_FADDR;
      end
      mfvn_pkg::ST_CDONE:  state_next = mfvn_pkg::ST_IDLE;
      default:             state_next = mfvn_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= '0;
      fcount     <= '0;
      sums_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == mfvn_pkg::REG_VERTEX_COUNT) vcount <= mfvn_pkg::CNT_W'(cfg_data);
        if (cfg_index == mfvn_pkg::REG_FACE_COUNT) fcount <= mfvn_pkg::CNT_W'(cfg_data);
      end
      if (accept && request.func == mfvn_pkg::FUNC_COMPUTE && nv != '0 && nf != '0) begin
        sums_valid <= 1'b1;
      end
      done <= (accept && state_next == mfvn_pkg::ST_IDLE) ||
              (state == mfvn_pkg::ST_FREAD) || (state == mfvn_pkg::ST_CDONE) ||
              ((state == mfvn_pkg::ST_VNORM) && norm_res.done);
    end
  end

  // datapath and result word
  always_ff @(posedge clk) begin
    unique case (state)
      mfvn_pkg::ST_IDLE: begin
        result    <= '0;
        bad_acc   <= (32'(vcount) > mfvn_pkg::MAX_VERTICES) ||
                     (32'(fcount) > mfvn_pkg::MAX_FACES);
        degen_acc <= 1'b0;
        clr_addr  <= '0;
        face      <= '0;
        unique case (request.func)
          mfvn_pkg::FUNC_LOAD_VERTEX: result.status <= vtx_ok ? mfvn_pkg::STATUS_OK :
                                                       mfvn_pkg::STATUS_RANGE;
          mfvn_pkg::FUNC_LOAD_FACE:   result.status <= (face_ok && !load_bad) ?
                                                       mfvn_pkg::STATUS_OK :
                                                       mfvn_pkg::STATUS_RANGE;
          mfvn_pkg::FUNC_COMPUTE:     result.status <= mfvn_pkg::STATUS_OK;
          default:                    result.status <= mfvn_pkg::STATUS_RANGE;
        endcase
      end
      mfvn_pkg::ST_FREAD: begin
        if (fn_rdata[48]) begin
          result <= '0;
          result.status <= mfvn_pkg::STATUS_RANGE;
        end else begin
          result.norm_x <= fn_rdata[47:32];
          result.norm_y <= fn_rdata[31:16];
          result.norm_z <= fn_rdata[15:0];
          result.status <= (fn_rdata[47:0] == '0) ? mfvn_pkg::STATUS_DEGEN :
                           mfvn_pkg::STATUS_OK;
        end
      end
      mfvn_pkg::ST_VNORM: begin
        result.norm_x <= norm_res.x;
        result.norm_y <= norm_res.y;
        result.norm_z <= norm_res.z;
        result.status <= norm_res.degen ? mfvn_pkg::STATUS_DEGEN : mfvn_pkg::STATUS_OK;
      end
      mfvn_pkg::ST_CLEAR: clr_addr <= clr_addr + VW'(1);
      mfvn_pkg::ST_FCHECK: begin
        corner[0] <= rc[0];
        corner[1] <= rc[1];
        corner[2] <= rc[2];
        if (rc_bad) begin
          bad_acc <= 1'b1;
          face    <= face + FW'(1);
        end
      end
      mfvn_pkg::ST_PA: begin
        pa[0] <= pos_rdata[95:64];
        pa[1] <= pos_rdata[63:32];
        pa[2] <= pos_rdata[31:0];
      end
      mfvn_pkg::ST_PB: begin
        pb[0] <= pos_rdata[95:64];
        pb[1] <= pos_rdata[63:32];
        pb[2] <= pos_rdata[31:0];
      end
      mfvn_pkg::ST_PC: begin
        for (int i = 0; i < 3; i++) begin
          d33[i] <= 33'(pb[i]) - 33'(pa[i]);
        end
        d33[3] <= 33'($signed(pos_rdata[95:64])) - 33'(pa[0]);
        d33[4] <= 33'($signed(pos_rdata[63:32])) - 33'(pa[1]);
        d33[5] <= 33'($signed(pos_rdata[31:0])) - 33'(pa[2]);
      end
      mfvn_pkg::ST_DSHIFT: begin
        for (int i = 0; i < 6; i++) begin
          d[i] <= (d33[i] < 0) ? -$signed(31'(dmag[i] >> dsh)) : $signed(31'(dmag[i] >> dsh));
        end
        mcnt <= 3'd0;
      end
      // one product per cycle, folded into the cross product in the next cycle
      mfvn_pkg::ST_MUL: begin
        prod <= opa * opb;
        unique case (mcnt)
          3'd1:    cr[0] <= 64'(prod);
          3'd2:    cr[0] <= cr[0] - 64'(prod);
          3'd3:    cr[1] <= 64'(prod);
          3'd4:    cr[1] <= cr[1] - 64'(prod);
          3'd5:    cr[2] <= 64'(prod);
          3'd6:    cr[2] <= cr[2] - 64'(prod);
          default: begin
          end
        endcase
        mcnt <= mcnt + 3'd1;
      end
      mfvn_pkg::ST_FNORM: begin
        nrm[0] <= norm_res.x;
        nrm[1] <= norm_res.y;
        nrm[2] <= norm_res.z;
        if (norm_res.done && norm_res.degen) degen_acc <= 1'b1;
        k <= 2'd0;
      end
      // read-modify-write of one corner's sum; accesses never overlap
      mfvn_pkg::ST_SUPD: begin
        k <= k + 2'd1;
        if (k == 2'd2) face <= face + FW'(1);
      end
      mfvn_pkg::ST_CDONE: begin
        result <= '0;
        result.status <= bad_acc ? mfvn_pkg::STATUS_RANGE :
                         (degen_acc ? mfvn_pkg::STATUS_DEGEN : mfvn_pkg::STATUS_OK);
      end
      default: begin
      end
    endcase
  end

endmodule
